[rtl/core/pps2_pkg.sv]
package pps2_pkg;

    typedef enum logic [1:0] {
        OP_REPORT = 2'd0,
        OP_READ   = 2'd1,
        OP_OPEN   = 2'd2,
        OP_CLOSE  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_CLOSED = 3'd1,
        ST_ZERO   = 3'd2,
        ST_FULL   = 3'd3,
        ST_EMPTY  = 3'd4
    } status_t;

    // what the back end has to do for one word
    typedef enum logic [1:0] {
        K_NONE  = 2'd0,
        K_PUSH  = 2'd1,
        K_READ  = 2'd2,
        K_FLUSH = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        BS_IDLE   = 3'd0,
        BS_WR_HDR = 3'd1,
        BS_WR_DX  = 3'd2,
        BS_WR_DY  = 3'd3,
        BS_RD     = 3'd4,
        BS_RESP   = 3'd5
    } back_state_t;

    localparam int PKT_LEN   = 3;
    localparam int DELTA_MAX = 255;
    localparam int DELTA_MIN = -256;

    localparam logic [7:0] HDR_SYNC = 8'h08;
    localparam logic [7:0] HDR_XNEG = 8'h10;
    localparam logic [7:0] HDR_YNEG = 8'h20;

    typedef struct packed {
        op_t                operation;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
    } cmd_t;

    typedef struct packed {
        status_t    status_code;
        logic [7:0] read_byte;
        logic       read_valid;
        logic [8:0] bytes_queued;
        logic       data_available;
    } res_t;

    typedef struct packed {
        kind_t      kind;
        status_t    status_code;
        logic       x_neg;
        logic       y_neg;
        logic [7:0] dx_byte;
        logic [7:0] dy_byte;
        logic [8:0] bytes_queued;
        logic       data_available;
    } desc_t;

endpackage

[rtl/core/pps2_front.sv]
module pps2_front #(
    parameter int QUEUE_DEPTH = 256
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  pps2_pkg::cmd_t   cmd,
    output pps2_pkg::desc_t  desc
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int QW = (AW > 9) ? AW : 9;
    localparam logic [AW:0] DEPTH_W = (AW + 1)'(QUEUE_DEPTH);
    localparam logic [AW:0] PKT_W = (AW + 1)'(pps2_pkg::PKT_LEN);
    localparam logic signed [16:0] DMAX = 17'(pps2_pkg::DELTA_MAX);
    localparam logic signed [16:0] DMIN = 17'(pps2_pkg::DELTA_MIN);

    logic                  is_open_reg, is_open_next;
    logic signed [15:0]    last_x_reg, last_x_next;
    logic signed [15:0]    last_y_reg, last_y_next;
    logic [AW-1:0]         count_reg, count_next;

    logic signed [16:0]    dx_full, dy_full;
    logic signed [16:0]    dx_sat, dy_sat;
    logic [AW:0]           count_plus;
    logic [QW-1:0]         count_wide;

    assign dx_full = {cmd.pos_x[15], cmd.pos_x} - {last_x_reg[15], last_x_reg};
    assign dy_full = {cmd.pos_y[15], cmd.pos_y} - {last_y_reg[15], last_y_reg};
    assign count_plus = {1'b0, count_reg} + PKT_W;

    always_comb
    begin
        if (dx_full > DMAX)
            dx_sat = DMAX;
        else if (dx_full < DMIN)
            dx_sat = DMIN;
        else
            dx_sat = dx_full;
        if (dy_full > DMAX)
            dy_sat = DMAX;
        else if (dy_full < DMIN)
            dy_sat = DMIN;
        else
            dy_sat = dy_full;
    end

    always_comb
    begin
        is_open_next = is_open_reg;
        last_x_next  = last_x_reg;
        last_y_next  = last_y_reg;
        count_next   = count_reg;
        desc.kind        = pps2_pkg::K_NONE;
        desc.status_code = pps2_pkg::ST_OK;
        desc.x_neg       = dx_full[16];
        desc.y_neg       = dy_full[16];
        desc.dx_byte     = dx_sat[7:0];
        desc.dy_byte     = dy_sat[7:0];
        case (cmd.operation)
            pps2_pkg::OP_REPORT:
            begin
                if (!is_open_reg)
                    desc.status_code = pps2_pkg::ST_CLOSED;
                else if (dx_full == '0 && dy_full == '0)
                    desc.status_code = pps2_pkg::ST_ZERO;
                else
                begin
                    last_x_next = cmd.pos_x;
                    last_y_next = cmd.pos_y;
                    if (count_plus < DEPTH_W)
                    begin
                        desc.kind  = pps2_pkg::K_PUSH;
                        count_next = count_plus[AW-1:0];
                    end
                    else
                        desc.status_code = pps2_pkg::ST_FULL;
                end
            end
            pps2_pkg::OP_READ:
            begin
                if (count_reg == '0)
                    desc.status_code = pps2_pkg::ST_EMPTY;
                else
                begin
                    desc.kind  = pps2_pkg::K_READ;
                    count_next = count_reg - 1'b1;
                end
            end
            pps2_pkg::OP_OPEN:
            begin
                if (!is_open_reg)
                begin
                    desc.kind    = pps2_pkg::K_FLUSH;
                    count_next   = '0;
                    is_open_next = 1'b1;
                end
            end
            pps2_pkg::OP_CLOSE:
                is_open_next = 1'b0;
            default:
                is_open_next = is_open_reg;
        endcase
        count_wide          = QW'(count_next);
        desc.bytes_queued   = count_wide[8:0];
        desc.data_available = (count_next != '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            is_open_reg <= 1'b0;
            last_x_reg  <= '0;
            last_y_reg  <= '0;
            count_reg   <= '0;
        end
        else if (accept)
        begin
            is_open_reg <= is_open_next;
            last_x_reg  <= last_x_next;
            last_y_reg  <= last_y_next;
            count_reg   <= count_next;
        end
    end

endmodule

[rtl/core/pps2_queue.sv]
module pps2_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  pps2_pkg::desc_t  push_word,
    input  logic             pop,
    output pps2_pkg::desc_t  head_word,
    output logic             empty,
    output logic             full
);

    // two slots, enough to keep the front end taking words while a packet is written
    pps2_pkg::desc_t slot_reg [2];
    logic            wr_ptr_reg, rd_ptr_reg;
    logic [1:0]      fill_reg;

    assign empty     = (fill_reg == 2'd0);
    assign full      = (fill_reg == 2'd2);
    assign head_word = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_word;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (push && !pop)
                fill_reg <= fill_reg + 2'd1;
            else if (pop && !push)
                fill_reg <= fill_reg - 2'd1;
        end
    end

endmodule

[rtl/core/pps2_back.sv]
module pps2_back #(
    parameter int QUEUE_DEPTH = 256
) (
    input  logic             clk,
    input  logic             rst_n,
    input  pps2_pkg::desc_t  head_word,
    input  logic             empty,
    output logic             pop,
    output logic             done,
    output pps2_pkg::res_t   result
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam logic [AW-1:0] LAST_IDX = AW'(QUEUE_DEPTH - 1);

    pps2_pkg::back_state_t state_reg, state_next;
    pps2_pkg::desc_t       cur_reg;
    logic [AW-1:0]         wr_ptr_reg, rd_ptr_reg;
    logic [7:0]            rdata_reg;
    logic [7:0]            byte_mem [QUEUE_DEPTH];

    logic                  mem_we, mem_re;
    logic [AW-1:0]         mem_addr;
    logic [7:0]            wdata;
    logic [7:0]            hdr;

    assign hdr = pps2_pkg::HDR_SYNC
               | (cur_reg.x_neg ? pps2_pkg::HDR_XNEG : 8'h00)
               | (cur_reg.y_neg ? pps2_pkg::HDR_YNEG : 8'h00);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pps2_pkg::BS_IDLE:
            begin
                if (!empty)
                begin
                    case (head_word.kind)
                        pps2_pkg::K_PUSH: state_next = pps2_pkg::BS_WR_HDR;
                        pps2_pkg::K_READ: state_next = pps2_pkg::BS_RD;
                        default:          state_next = pps2_pkg::BS_RESP;
                    endcase
                end
            end
            pps2_pkg::BS_WR_HDR: state_next = pps2_pkg::BS_WR_DX;
            pps2_pkg::BS_WR_DX:  state_next = pps2_pkg::BS_WR_DY;
            pps2_pkg::BS_WR_DY:  state_next = pps2_pkg::BS_RESP;
            pps2_pkg::BS_RD:     state_next = pps2_pkg::BS_RESP;
            pps2_pkg::BS_RESP:   state_next = pps2_pkg::BS_IDLE;
            default:             state_next = pps2_pkg::BS_IDLE;
        endcase
    end

    always_comb
    begin
        pop      = 1'b0;
        done     = 1'b0;
        mem_we   = 1'b0;
        mem_re   = 1'b0;
        mem_addr = wr_ptr_reg;
        wdata    = hdr;
        case (state_reg)
            pps2_pkg::BS_IDLE:   pop = !empty;
            pps2_pkg::BS_WR_HDR: mem_we = 1'b1;
            pps2_pkg::BS_WR_DX:
            begin
                mem_we = 1'b1;
                wdata  = cur_reg.dx_byte;
            end
            pps2_pkg::BS_WR_DY:
            begin
                mem_we = 1'b1;
                wdata  = cur_reg.dy_byte;
            end
            pps2_pkg::BS_RD:
            begin
                mem_re   = 1'b1;
                mem_addr = rd_ptr_reg;
            end
            pps2_pkg::BS_RESP:   done = 1'b1;
            default:             pop = 1'b0;
        endcase
    end

    assign result.status_code    = cur_reg.status_code;
    assign result.read_valid     = (cur_reg.kind == pps2_pkg::K_READ);
    assign result.read_byte      = result.read_valid ? rdata_reg : 8'h00;
    assign result.bytes_queued   = cur_reg.bytes_queued;
    assign result.data_available = cur_reg.data_available;

    // single port byte store
    always_ff @(posedge clk)
    begin
        if (mem_we)
            byte_mem[mem_addr] <= wdata;
        if (mem_re)
            rdata_reg <= byte_mem[mem_addr];
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            cur_reg <= head_word;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= pps2_pkg::BS_IDLE;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (pop && head_word.kind == pps2_pkg::K_FLUSH)
            begin
                wr_ptr_reg <= '0;
                rd_ptr_reg <= '0;
            end
            else
            begin
                if (mem_we)
                    wr_ptr_reg <= (wr_ptr_reg == LAST_IDX) ? '0 : wr_ptr_reg + 1'b1;
                if (mem_re)
                    rd_ptr_reg <= (rd_ptr_reg == LAST_IDX) ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

endmodule

[rtl/core/position_to_ps2_packet_fifo.sv]
// absolute x/y reports go in as commands (start while busy is low) and come out as
// relative three-byte ps/2 packets in a byte ring of QUEUE_DEPTH entries; every command
// gives exactly one result, shown for one cycle with done high, and the receiver cannot
// stall it. the front end decides each word in the cycle it is taken and drops a
// descriptor into a two-slot queue, so busy only rises when that queue is full. the back
// end owns the single-port byte store: a queued packet is picked up, gets three byte writes
// and is then presented, a read is picked up, reads one byte and is presented, and every
// other command is picked up and presented. the back end finishes each word before it
// picks up the next, and results come out in command order.
module position_to_ps2_packet_fifo #(
    parameter int QUEUE_DEPTH = 256
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  pps2_pkg::cmd_t  cmd,
    output logic            done,
    output pps2_pkg::res_t  result
);

    pps2_pkg::desc_t front_word;
    pps2_pkg::desc_t head_word;
    logic            accept;
    logic            q_empty, q_full, q_pop;

    assign busy   = q_full;
    assign accept = start && !q_full;

    pps2_front #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .cmd    (cmd),
        .desc   (front_word)
    );

    pps2_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_word (front_word),
        .pop       (q_pop),
        .head_word (head_word),
        .empty     (q_empty),
        .full      (q_full)
    );

    pps2_back #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_word (head_word),
        .empty     (q_empty),
        .pop       (q_pop),
        .done      (done),
        .result    (result)
    );

endmodule

[rtl/core/pps2_checker.sv]
module pps2_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            done,
    input pps2_pkg::res_t  result
);

    // a result strobe never stays up across consecutive cycles
    assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("result strobe held for two cycles");

    assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.read_valid) |-> (result.status_code == pps2_pkg::ST_OK))
        else $error("popped byte with a failing status");

    assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.read_valid) |-> (result.read_byte == 8'h00))
        else $error("read byte not zero without a pop");

    assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.bytes_queued != 9'd0) |-> result.data_available)
        else $error("bytes queued but none flagged available");

    assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status_code == pps2_pkg::ST_EMPTY) |-> !result.data_available)
        else $error("empty read while bytes are available");

endmodule

bind position_to_ps2_packet_fifo pps2_checker u_pps2_checker (.*);
